@@ hw/rtl/kht_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kht_pkg
// Shared widths, codes and defaults for the keyed hash table engine.
// ----------------------------------------------------------------------------
package kht_pkg;

   localparam int BUCKETS_DEF = 64;
   localparam int WAYS_DEF    = 4;

   localparam int LETTERS = 26;
   localparam int DIGITS  = 10;

   localparam int LETTER_W = 5;
   localparam int DIGIT_W  = 4;
   localparam int KEY_W    = 2 * LETTER_W + DIGIT_W;
   localparam int NUM_W    = 32;
   localparam int SIZE_W   = 7;
   localparam int HASH_W   = 14;   // 260*31 + 10*31 + 15 fits in 14 bits
   localparam int CNT_W    = $clog2(HASH_W);
   localparam int BKT_W    = 6;

   // slot word: valid, key, number
   localparam int SLOT_W    = 1 + KEY_W + NUM_W;
   localparam int VALID_BIT = SLOT_W - 1;

   localparam logic [SIZE_W-1:0] TSIZE_RST = 7'd64;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_SEARCH = 1'b1;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_DUPLICATE = 3'd1,
      ST_FOUND     = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_FULL      = 3'd4
   } status_type;

endpackage
`default_nettype wire

@@ hw/rtl/keyed_hash_table_insert_search.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// keyed_hash_table_insert_search
// Hash table of BUCKETS buckets with WAYS slots each; insert and search of
// three-character keys, bucket chosen by a configurable modulo.
// ----------------------------------------------------------------------------
//  channel | prefix | dir | payload
//  --------+--------+-----+--------------------------------------------------
//  request | req_   | in  | command, key letters and digit, entry_number
//  result  | rsp_   | out | status, bucket_index, found_number
//  config  | csr_   | in  | table_size
//
//  Each word passes the bit-serial modulo (14 steps) and then a scan of k
//  slots, k = slots examined (1..WAYS), each read through the registered
//  RAM read and then checked before the result is formed.
//  After reset a clearing pass writes every slot empty, during which no
//  request is taken; config writes are taken at any time.
//  A waiting result does not block the next request; that word then holds in
//  its last step until the result register is free.
// ----------------------------------------------------------------------------
module keyed_hash_table_insert_search
   import kht_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int WAYS    = WAYS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic                     req_command,
   input  wire logic [LETTER_W-1:0]      req_key_first_letter,
   input  wire logic [LETTER_W-1:0]      req_key_second_letter,
   input  wire logic [DIGIT_W-1:0]       req_key_digit,
   input  wire logic signed [NUM_W-1:0]  req_entry_number,

   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [BKT_W-1:0]              rsp_bucket_index,
   output logic signed [NUM_W-1:0]       rsp_found_number,

   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [SIZE_W-1:0]        csr_table_size
);

   localparam int DEPTH = BUCKETS * WAYS;
   localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int WW    = WAYS > 1 ? $clog2(WAYS) : 1;

   typedef enum logic [6:0] {
      S_CLEAR  = 7'b0000001,
      S_IDLE   = 7'b0000010,
      S_HASH   = 7'b0000100,
      S_BASE   = 7'b0001000,
      S_READ   = 7'b0010000,
      S_CHECK  = 7'b0100000,
      S_FINISH = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [SIZE_W-1:0]   tsize_ff, tsize_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                cmd_ff, cmd_in;
   logic [KEY_W-1:0]    key_ff, key_in;
   logic [NUM_W-1:0]    num_ff, num_in;
   logic [HASH_W-1:0]   dvd_ff, dvd_in;
   logic [SIZE_W-1:0]   div_ff, div_in;
   logic [SIZE_W-1:0]   rem_ff, rem_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [AW-1:0]       addr_ff, addr_in;
   logic [WW-1:0]       way_ff, way_in;
   status_type          res_status_ff, res_status_in;
   logic [NUM_W-1:0]    res_num_ff, res_num_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [BKT_W-1:0]    rsp_bucket_ff, rsp_bucket_in;
   logic [NUM_W-1:0]    rsp_num_ff, rsp_num_in;

   logic                ram_we;
   logic [SLOT_W-1:0]   ram_wdata;
   logic [SLOT_W-1:0]   rd_data;

   logic [SIZE_W-1:0]   div_eff;
   logic [HASH_W-1:0]   hash;
   logic [SIZE_W:0]     trial;
   logic                trial_ge;
   logic [SIZE_W-1:0]   rem_step;
   logic [AW-1:0]       base_addr;
   logic                slot_used;
   logic                key_hit;
   logic                out_free;

   kht_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (addr_ff),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   // size 0 acts as 1, sizes beyond the store are clamped
   always_comb begin
      if (tsize_ff == '0) begin
         div_eff = SIZE_W'(1);
      end else if (32'(tsize_ff) > BUCKETS) begin
         div_eff = SIZE_W'(BUCKETS);
      end else begin
         div_eff = tsize_ff;
      end
   end

   assign hash = HASH_W'(HASH_W'(req_key_first_letter) * HASH_W'(LETTERS * DIGITS))
               + HASH_W'(HASH_W'(req_key_second_letter) * HASH_W'(DIGITS))
               + HASH_W'(req_key_digit);

   // one restoring step of the remainder
   assign trial    = {rem_ff, dvd_ff[HASH_W-1]};
   assign trial_ge = trial >= {1'b0, div_ff};
   assign rem_step = trial_ge ? SIZE_W'(trial - {1'b0, div_ff}) : trial[SIZE_W-1:0];

   assign base_addr = AW'(rem_ff) * AW'(WAYS);
   assign slot_used = rd_data[VALID_BIT];
   assign key_hit   = slot_used && (rd_data[VALID_BIT-1 -: KEY_W] == key_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign req_ready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;

   always_comb begin
      state_in      = state_ff;
      tsize_in      = tsize_ff;
      rsp_valid_in  = rsp_valid_ff;
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      num_in        = num_ff;
      dvd_in        = dvd_ff;
      div_in        = div_ff;
      rem_in        = rem_ff;
      cnt_in        = cnt_ff;
      addr_in       = addr_ff;
      way_in        = way_ff;
      res_status_in = res_status_ff;
      res_num_in    = res_num_ff;
      rsp_status_in = rsp_status_ff;
      rsp_bucket_in = rsp_bucket_ff;
      rsp_num_in    = rsp_num_ff;
      ram_we        = 1'b0;
      ram_wdata     = '0;

      if (csr_valid) begin
         tsize_in = csr_table_size;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            if (addr_ff == AW'(DEPTH - 1)) begin
               addr_in  = '0;
               state_in = S_IDLE;
            end else begin
               addr_in = addr_ff + AW'(1);
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_command;
               key_in   = {req_key_first_letter, req_key_second_letter, req_key_digit};
               num_in   = req_entry_number;
               dvd_in   = hash;
               div_in   = div_eff;
               rem_in   = '0;
               cnt_in   = '0;
               state_in = S_HASH;
            end
         end
         S_HASH: begin
            rem_in = rem_step;
            dvd_in = {dvd_ff[HASH_W-2:0], 1'b0};
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(HASH_W - 1)) begin
               state_in = S_BASE;
            end
         end
         S_BASE: begin
            addr_in  = base_addr;
            way_in   = '0;
            state_in = S_READ;
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // slots fill from way 0 upward, so the first empty one ends the chain
            res_num_in = '0;
            priority if (!slot_used) begin
               if (cmd_ff == CMD_INSERT) begin
                  ram_we        = 1'b1;
                  ram_wdata     = {1'b1, key_ff, num_ff};
                  res_status_in = ST_INSERTED;
               end else begin
                  res_status_in = ST_NOT_FOUND;
               end
               state_in = S_FINISH;
            end else if (key_hit) begin
               if (cmd_ff == CMD_INSERT) begin
                  res_status_in = ST_DUPLICATE;
               end else begin
                  res_status_in = ST_FOUND;
                  res_num_in    = rd_data[NUM_W-1:0];
               end
               state_in = S_FINISH;
            end else if (way_ff == WW'(WAYS - 1)) begin
               res_status_in = (cmd_ff == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
               state_in      = S_FINISH;
            end else begin
               way_in   = way_ff + WW'(1);
               addr_in  = addr_ff + AW'(1);
               state_in = S_READ;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_bucket_in = BKT_W'(rem_ff);
               rsp_num_in    = res_num_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         tsize_ff     <= TSIZE_RST;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         tsize_ff     <= tsize_in;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      num_ff        <= num_in;
      dvd_ff        <= dvd_in;
      div_ff        <= div_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      way_ff        <= way_in;
      res_status_ff <= res_status_in;
      res_num_ff    <= res_num_in;
      rsp_status_ff <= rsp_status_in;
      rsp_bucket_ff <= rsp_bucket_in;
      rsp_num_ff    <= rsp_num_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_bucket_index = rsp_bucket_ff;
   assign rsp_found_number = rsp_num_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_HASH) |-> (rem_ff < div_ff))
      else $error("remainder not below divisor");

   a_write_only_insert: assert property (@(posedge clock) disable iff (reset)
      (ram_we && state_ff == S_CHECK) |-> (cmd_ff == CMD_INSERT && !slot_used))
      else $error("slot written other than by insert into empty slot");

   a_number_only_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_num_ff != '0) |-> (rsp_status_ff == ST_FOUND))
      else $error("number returned without found status");

   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result word raised outside finish");

endmodule
`default_nettype wire

@@ hw/rtl/kht_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// kht_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module kht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire
